[design/gsre_pkg.sv]
`timescale 1ns / 1ps

package gsre_pkg;

  // Largest block length in bytes and the 13-bit length field it saturates in.
  localparam int BlockBytes = 4096;
  localparam int LenW       = 13;
  localparam int LenFieldMax = (1 << LenW) - 1;
  localparam logic [LenW-1:0] LenCap =
    LenW'((BlockBytes > LenFieldMax) ? LenFieldMax : BlockBytes);

  localparam int ValW  = 7;
  localparam int ByteW = 8;

  // At most three bytes can come from one sample: a run break gives a marker
  // and a value, after which the block end flushes the single new value.
  localparam int SlotN = 3;
  localparam int SlotCntW = 2;

  localparam int QDepth = 4;
  localparam int QAddrW = 2;

  typedef struct packed {
    logic [ByteW-1:0] code;
    logic             mark;
  } slot_t;

  typedef struct packed {
    logic [SlotCntW-1:0]     n;
    slot_t [SlotN-1:0]       slot;
    logic                    fin;
  } desc_t;

  typedef struct packed {
    logic  push;
    desc_t desc;
  } fe_req_t;

  typedef struct packed {
    logic full;
  } fe_stat_t;

  function automatic slot_t mk_mark(input logic [ValW-1:0] cnt);
    slot_t s;
    s.code = {1'b1, cnt};
    s.mark = 1'b1;
    return s;
  endfunction

  function automatic slot_t mk_val(input logic [ValW-1:0] v);
    slot_t s;
    s.code = {1'b0, v};
    s.mark = 1'b0;
    return s;
  endfunction

endpackage

[design/gsre_in_if.sv]
`timescale 1ns / 1ps

interface gsre_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample;
  logic       block_end;

  modport source(output valid, output sample, output block_end, input ready);
  modport sink(input valid, input sample, input block_end, output ready);
endinterface

[design/gsre_out_if.sv]
`timescale 1ns / 1ps

interface gsre_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  code_byte;
  logic        is_marker;
  logic        item_done;
  logic        stream_done;
  logic [12:0] total_length;

  modport source(output valid, output code_byte, output is_marker, output item_done,
                 output stream_done, output total_length, input ready);
  modport sink(input valid, input code_byte, input is_marker, input item_done,
               input stream_done, input total_length, output ready);
endinterface

[design/gsre_front.sv]
`timescale 1ns / 1ps

module gsre_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [6:0]                cfg_wdata_i,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [7:0]                sample_i,
  input  logic                      block_end_i,
  input  gsre_pkg::fe_stat_t        stat_i,
  output gsre_pkg::fe_req_t         req_o
);
  import gsre_pkg::*;

  logic [ValW-1:0] max_run_q;
  logic [ValW-1:0] held_q, held_d;
  logic [ValW-1:0] run_q, run_d;
  logic            primed_q, primed_d;
  logic            accept;
  logic [ValW-1:0] v;
  desc_t           desc;
  logic [SlotCntW-1:0] pos;

  assign ready_o = !stat_i.full;
  assign accept  = valid_i && ready_o;
  assign v       = sample_i[7:1];

  always_comb begin
    held_d   = held_q;
    run_d    = run_q;
    primed_d = primed_q;
    desc     = '0;
    pos      = '0;
    if (accept) begin
      if (!primed_q) begin
        held_d   = v;
        run_d    = '0;
        primed_d = 1'b1;
      end else begin
        if ((v == held_q) && (run_q < max_run_q)) begin
          run_d = run_q + ValW'(1);
        end else if (run_q != '0) begin
          desc.slot[pos] = mk_mark(run_q);
          pos            = pos + SlotCntW'(1);
          desc.slot[pos] = mk_val(held_q);
          pos            = pos + SlotCntW'(1);
          run_d          = '0;
        end else begin
          desc.slot[pos] = mk_val(held_q);
          pos            = pos + SlotCntW'(1);
        end
        held_d = v;
      end
      if (block_end_i) begin
        if (run_d != '0) begin
          desc.slot[pos] = mk_mark(run_d);
          pos            = pos + SlotCntW'(1);
        end
        desc.slot[pos] = mk_val(held_d);
        pos            = pos + SlotCntW'(1);
        desc.fin       = 1'b1;
        held_d         = '0;
        run_d          = '0;
        primed_d       = 1'b0;
      end
    end
    desc.n = pos;
  end

  assign req_o.push = accept && (pos != '0);
  assign req_o.desc = desc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_run_q <= 7'd127;
      held_q    <= '0;
      run_q     <= '0;
      primed_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_run_q <= cfg_wdata_i;
      end
      held_q   <= held_d;
      run_q    <= run_d;
      primed_q <= primed_d;
    end
  end

endmodule

[design/gsre_fifo.sv]
`timescale 1ns / 1ps

module gsre_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gsre_pkg::fe_req_t  req_i,
  output gsre_pkg::fe_stat_t stat_o,
  output logic               valid_o,
  output gsre_pkg::desc_t    desc_o,
  input  logic               pop_i
);
  import gsre_pkg::*;

  desc_t             mem_q [QDepth];
  logic [QAddrW-1:0] wr_q, rd_q;
  logic [QAddrW:0]   cnt_q;
  logic              do_push, do_pop;

  assign stat_o.full = (cnt_q == (QAddrW+1)'(QDepth));
  assign valid_o     = (cnt_q != '0);
  assign desc_o      = mem_q[rd_q];
  assign do_push     = req_i.push && !stat_o.full;
  assign do_pop      = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= req_i.desc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + QAddrW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QAddrW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + (QAddrW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (QAddrW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[design/gsre_back.sv]
`timescale 1ns / 1ps

module gsre_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  gsre_pkg::desc_t   desc_i,
  output logic              pop_o,
  gsre_out_if.source        out_o
);
  import gsre_pkg::*;

  logic [SlotCntW-1:0] idx_q;
  logic [LenW-1:0]     len_q;
  logic [LenW-1:0]     len_nxt;
  logic                load;
  logic                final_byte;
  logic                out_valid_q;
  slot_t               cur;
  logic [ByteW-1:0]    code_q;
  logic                mark_q, item_q, stream_q;
  logic [LenW-1:0]     tot_q;

  assign load       = valid_i && (!out_valid_q || out_o.ready);
  assign final_byte = (idx_q == (desc_i.n - SlotCntW'(1)));
  assign pop_o      = load && final_byte;
  assign cur        = desc_i.slot[idx_q];
  assign len_nxt    = (len_q < LenCap) ? (len_q + LenW'(1)) : len_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      code_q   <= cur.code;
      mark_q   <= cur.mark;
      item_q   <= final_byte;
      stream_q <= final_byte && desc_i.fin;
      tot_q    <= len_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      len_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= final_byte ? '0 : (idx_q + SlotCntW'(1));
        len_q       <= (final_byte && desc_i.fin) ? '0 : len_nxt;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.code_byte    = code_q;
  assign out_o.is_marker    = mark_q;
  assign out_o.item_done    = item_q;
  assign out_o.stream_done  = stream_q;
  assign out_o.total_length = tot_q;

endmodule

[design/grey_sample_run_length_encoder_unit.sv]
// A sample's descriptor is queued at its input transfer edge, and the output register
// loads the sample's first byte from the queue head once that register is free.
// Throughput: one sample per cycle while each gives at most one byte and nothing stalls;
// unstalled, the output register moves one byte per cycle; a run break gives two bytes.
// A four-entry descriptor queue lets input and output stall independently.
// Reset (rst_ni low, asynchronous) empties the queue and the output register,
// clears the run state and length count, and sets max_run to 127.
`timescale 1ns / 1ps

module grey_sample_run_length_encoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  gsre_in_if.sink     in_i,
  gsre_out_if.source  out_o
);
  import gsre_pkg::*;

  // The front end keeps the held value, the run count and the primed flag. For
  // each accepted sample it works out, combinationally, the bytes that sample
  // releases and packs them into a descriptor. Samples that release nothing (a run
  // still growing, or a block's first sample, unless it ends the block) push no descriptor.
  fe_req_t  fe_req;
  fe_stat_t fe_stat;
  logic     q_valid;
  desc_t    q_desc;
  logic     q_pop;

  gsre_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .valid_i     (in_i.valid),
    .ready_o     (in_i.ready),
    .sample_i    (in_i.sample),
    .block_end_i (in_i.block_end),
    .stat_i      (fe_stat),
    .req_o       (fe_req)
  );

  // The queue holds descriptors so that a stalled output does not hold up the
  // input side until it is full.
  gsre_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (fe_req),
    .stat_o  (fe_stat),
    .valid_o (q_valid),
    .desc_o  (q_desc),
    .pop_i   (q_pop)
  );

  // The back end walks the bytes of the head descriptor one per transfer,
  // keeps the saturating byte count of the block, and flags the last byte of
  // each sample and of the block. The count restarts after the block's last byte.
  gsre_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .desc_i  (q_desc),
    .pop_o   (q_pop),
    .out_o   (out_o)
  );

endmodule

[design/gsre_checker.sv]
`timescale 1ns / 1ps

module gsre_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  code_byte_i,
  input logic        is_marker_i,
  input logic        item_done_i,
  input logic        stream_done_i,
  input logic [12:0] total_length_i
);
  import gsre_pkg::*;

  // A stalled byte holds still until it is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(code_byte_i) && $stable(total_length_i)))
    else $error("output byte changed while stalled");

  // The last byte of a block is always the last byte of its sample.
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && stream_done_i) |-> item_done_i)
    else $error("stream_done without item_done");

  // Markers carry the top bit, values never do.
  a_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (is_marker_i == code_byte_i[7]))
    else $error("marker flag disagrees with code byte");

  // Every byte counts itself, and the count never passes the block limit.
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((total_length_i != '0) && (total_length_i <= LenCap)))
    else $error("total length out of range");

endmodule

bind grey_sample_run_length_encoder_unit gsre_checker u_gsre_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .code_byte_i    (out_o.code_byte),
  .is_marker_i    (out_o.is_marker),
  .item_done_i    (out_o.item_done),
  .stream_done_i  (out_o.stream_done),
  .total_length_i (out_o.total_length)
);
